/* hdl/ofun_pkg.sv */
package ofun_pkg;

	localparam int NORMAL_FRAC_BITS_DEF = 14;
	localparam int CoordW = 32;
	localparam int DiffW  = 33;
	localparam int ProdW  = 66;
	localparam int CrossW = 67;
	localparam int MagW   = 66;
	localparam int DotW   = 102;
	localparam int TopW   = 31;

	typedef struct packed {
		logic [2:0][MagW-1:0] mag;
		logic [2:0]           neg;
		logic                 flip;
	} mag_t;

	typedef struct packed {
		logic [2:0][TopW-1:0] m;
		logic [2:0]           neg;
		logic                 flip;
		logic                 degen;
	} meta_t;

endpackage

/* hdl/ofun_cross.sv */
module ofun_cross (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   ce,
	input  logic                                   in_vld,
	input  logic [11:0][ofun_pkg::CoordW-1:0]      pts,
	output logic                                   out_vld,
	output logic signed [2:0][ofun_pkg::CrossW-1:0] n,
	output logic signed [2:0][ofun_pkg::DiffW-1:0]  c
);
	localparam int DW = ofun_pkg::DiffW;
	localparam int PW = ofun_pkg::ProdW;

	logic signed [2:0][DW-1:0] a_s1, b_s1, c_s1, c_s2;
	logic signed [5:0][PW-1:0] p_s2;
	logic vld_s1, vld_s2;

	function automatic logic signed [DW-1:0] dif(input logic [31:0] u, input logic [31:0] v);
		return $signed({u[31], u}) - $signed({v[31], v});
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else if (ce) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i] <= dif(pts[3+i], pts[i]);
				b_s1[i] <= dif(pts[6+i], pts[i]);
				c_s1[i] <= dif(pts[9+i], pts[i]);
			end
			p_s2[0] <= $signed(a_s1[1]) * $signed(b_s1[2]);
			p_s2[1] <= $signed(a_s1[2]) * $signed(b_s1[1]);
			p_s2[2] <= $signed(a_s1[2]) * $signed(b_s1[0]);
			p_s2[3] <= $signed(a_s1[0]) * $signed(b_s1[2]);
			p_s2[4] <= $signed(a_s1[0]) * $signed(b_s1[1]);
			p_s2[5] <= $signed(a_s1[1]) * $signed(b_s1[0]);
			c_s2 <= c_s1;
			for (int i = 0; i < 3; i++) begin
				n[i] <= $signed({p_s2[2*i][PW-1], p_s2[2*i]})
					- $signed({p_s2[2*i+1][PW-1], p_s2[2*i+1]});
			end
			c <= c_s2;
		end
	end

endmodule

/* hdl/ofun_orient.sv */
module ofun_orient (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    ce,
	input  logic                                    in_vld,
	input  logic signed [2:0][ofun_pkg::CrossW-1:0] n,
	input  logic signed [2:0][ofun_pkg::DiffW-1:0]  c,
	output logic                                    out_vld,
	output ofun_pkg::mag_t                          out_mag
);
	localparam int NW = ofun_pkg::CrossW;
	localparam int DW = ofun_pkg::DotW;
	localparam int MW = ofun_pkg::MagW;

	// n split as hi * 2^34 + lo
	logic signed [2:0][67:0] pl_s1;
	logic signed [2:0][65:0] ph_s1;
	logic signed [2:0][NW-1:0] n_s1;
	logic signed [2:0][DW-1:0] t_s2;
	logic [2:0][MW-1:0] mag_s2;
	logic [2:0] neg_s2;
	logic vld_s1, vld_s2;
	logic signed [DW-1:0] dot;

	assign dot = t_s2[0] + t_s2[1] + t_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			out_vld <= 1'b0;
		end else if (ce) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			out_vld <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				pl_s1[i] <= $signed({1'b0, n[i][33:0]}) * $signed(c[i]);
				ph_s1[i] <= $signed(n[i][NW-1:34]) * $signed(c[i]);
				n_s1[i]  <= n[i];
				t_s2[i]  <= ($signed({{(DW-66){ph_s1[i][65]}}, ph_s1[i]}) <<< 34)
					+ $signed({{(DW-68){pl_s1[i][67]}}, pl_s1[i]});
				neg_s2[i] <= n_s1[i][NW-1];
				mag_s2[i] <= n_s1[i][NW-1] ? MW'(-n_s1[i]) : MW'(n_s1[i]);
			end
			out_mag.mag  <= mag_s2;
			out_mag.neg  <= neg_s2 ^ {3{dot[DW-1]}};
			out_mag.flip <= dot[DW-1];
		end
	end

endmodule

/* hdl/ofun_scale.sv */
module ofun_scale (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ce,
	input  logic           in_vld,
	input  ofun_pkg::mag_t in_mag,
	output logic           out_vld,
	output logic [63:0]    out_r2,
	output ofun_pkg::meta_t out_meta
);
	localparam int MW = ofun_pkg::MagW;
	localparam int TW = ofun_pkg::TopW;

	ofun_pkg::mag_t mag_s1;
	logic [6:0] len_s1;
	ofun_pkg::meta_t meta_s2, meta_s3;
	logic [2:0][61:0] sq_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic [MW-1:0] any;

	function automatic logic [6:0] bitlen(input logic [MW-1:0] v);
		logic [6:0] l;
		l = '0;
		for (int i = 0; i < MW; i++) begin
			if (v[i]) l = 7'(i + 1);
		end
		return l;
	endfunction

	assign any = in_mag.mag[0] | in_mag.mag[1] | in_mag.mag[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			out_vld <= 1'b0;
		end else if (ce) begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			out_vld <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			mag_s1 <= in_mag;
			len_s1 <= bitlen(any);
			for (int i = 0; i < 3; i++) begin
				if (len_s1 > 7'(TW))
					meta_s2.m[i] <= TW'(mag_s1.mag[i] >> (len_s1 - 7'(TW)));
				else
					meta_s2.m[i] <= TW'(mag_s1.mag[i] << (7'(TW) - len_s1));
			end
			meta_s2.neg   <= mag_s1.neg;
			meta_s2.flip  <= mag_s1.flip;
			meta_s2.degen <= (len_s1 == '0);
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= meta_s2.m[i] * meta_s2.m[i];
			end
			meta_s3  <= meta_s2;
			out_r2   <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
			out_meta <= meta_s3;
		end
	end

endmodule

/* hdl/ofun_isqrt.sv */
module ofun_isqrt (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ce,
	input  logic            in_vld,
	input  logic [63:0]     in_r2,
	input  ofun_pkg::meta_t in_meta,
	output logic            out_vld,
	output logic [31:0]     out_r,
	output ofun_pkg::meta_t out_meta
);
	localparam int Steps = 32;

	logic [63:0] rem_s [0:Steps];
	logic [63:0] res_s [0:Steps];
	ofun_pkg::meta_t meta_s [0:Steps];
	logic vld_s [0:Steps];

	assign rem_s[0]  = in_r2;
	assign res_s[0]  = '0;
	assign meta_s[0] = in_meta;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
		logic [63:0] t;
		assign t = res_s[k] + Bit;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ce) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				if (rem_s[k] >= t) begin
					rem_s[k+1] <= rem_s[k] - t;
					res_s[k+1] <= (res_s[k] >> 1) + Bit;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				meta_s[k+1] <= meta_s[k];
			end
		end
	end

	assign out_vld  = vld_s[Steps];
	assign out_r    = res_s[Steps][31:0];
	assign out_meta = meta_s[Steps];

endmodule

/* hdl/ofun_div.sv */
module ofun_div #(
	parameter int FracBits = ofun_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            ce,
	input  logic            in_vld,
	input  logic [31:0]     in_r,
	input  ofun_pkg::meta_t in_meta,
	output logic            out_vld,
	output logic [2:0][15:0] normal,
	output logic            flipped,
	output logic            degenerate
);
	localparam int QW = FracBits + 1;
	localparam int NW = 32 + FracBits;
	localparam int TW = ofun_pkg::TopW;

	logic [31:0]    rem_s  [0:QW][0:2];
	logic [QW-1:0]  low_s  [0:QW][0:2];
	logic [QW-1:0]  q_s    [0:QW][0:2];
	logic [31:0]    r_s    [0:QW];
	ofun_pkg::meta_t meta_s [0:QW];
	logic           vld_s  [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			out_vld  <= 1'b0;
		end else if (ce) begin
			vld_s[0] <= in_vld;
			out_vld  <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [NW-1:0] num;
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				num = (NW'(in_meta.m[i]) << FracBits) + NW'(in_r >> 1);
				rem_s[0][i] <= 32'(num >> QW);
				low_s[0][i] <= num[QW-1:0];
				q_s[0][i]   <= '0;
			end
			r_s[0]    <= in_r;
			meta_s[0] <= in_meta;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ce) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			logic [32:0] t;
			if (ce) begin
				for (int i = 0; i < 3; i++) begin
					t = {rem_s[k][i], low_s[k][i][QW-1]};
					if (t >= {1'b0, r_s[k]}) begin
						rem_s[k+1][i] <= 32'(t - {1'b0, r_s[k]});
						q_s[k+1][i]   <= {q_s[k][i][QW-2:0], 1'b1};
					end else begin
						rem_s[k+1][i] <= t[31:0];
						q_s[k+1][i]   <= {q_s[k][i][QW-2:0], 1'b0};
					end
					low_s[k+1][i] <= low_s[k][i] << 1;
				end
				r_s[k+1]    <= r_s[k];
				meta_s[k+1] <= meta_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] q;
		if (ce) begin
			for (int i = 0; i < 3; i++) begin
				q = 32'(q_s[QW][i]);
				if (q > (32'd1 << FracBits)) q = 32'd1 << FracBits;
				if (meta_s[QW].degen) begin
					normal[i] <= '0;
				end else if (meta_s[QW].neg[i]) begin
					if (q > 32'd32768) q = 32'd32768;
					normal[i] <= 16'(32'd0 - q);
				end else begin
					if (q > 32'd32767) q = 32'd32767;
					normal[i] <= q[15:0];
				end
			end
			flipped    <= meta_s[QW].flip;
			degenerate <= meta_s[QW].degen;
		end
	end

endmodule

/* hdl/oriented_face_unit_normal_top.sv */
// Throughput: one face per cycle while the output register is empty or taken;
// stages are 3 cross, 3 orient, 4 scale, 32 sqrt, NORMAL_FRAC_BITS+3 divide.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset: arst_n asynchronously clears all valid bits; datapath registers are not reset.
module oriented_face_unit_normal_top #(
	parameter int NORMAL_FRAC_BITS = ofun_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z center_x center_y center_z
	input  logic [383:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// normal_x normal_y normal_z
	output logic [47:0]  m_axis_tdata,
	// flipped degenerate
	output logic [1:0]   m_axis_tuser
);
	logic ce;
	logic v_cross, v_orient, v_scale, v_sqrt;
	logic signed [2:0][ofun_pkg::CrossW-1:0] n;
	logic signed [2:0][ofun_pkg::DiffW-1:0] c;
	ofun_pkg::mag_t mag;
	ofun_pkg::meta_t meta_scale, meta_sqrt;
	logic [63:0] r2;
	logic [31:0] r;
	logic [2:0][15:0] normal;

	assign ce = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = ce;

	ofun_cross u_cross (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(s_axis_tvalid),
		.pts(s_axis_tdata), .out_vld(v_cross), .n(n), .c(c)
	);

	ofun_orient u_orient (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(v_cross),
		.n(n), .c(c), .out_vld(v_orient), .out_mag(mag)
	);

	ofun_scale u_scale (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(v_orient), .in_mag(mag),
		.out_vld(v_scale), .out_r2(r2), .out_meta(meta_scale)
	);

	ofun_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(v_scale), .in_r2(r2),
		.in_meta(meta_scale), .out_vld(v_sqrt), .out_r(r), .out_meta(meta_sqrt)
	);

	ofun_div #(.FracBits(NORMAL_FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .ce(ce), .in_vld(v_sqrt), .in_r(r),
		.in_meta(meta_sqrt), .out_vld(m_axis_tvalid), .normal(normal),
		.flipped(m_axis_tuser[0]), .degenerate(m_axis_tuser[1])
	);

	assign m_axis_tdata = normal;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
		else $error("degenerate beat with nonzero normal");

	a_degen_noflip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
		else $error("degenerate beat marked flipped");

	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata != '0)
		else $error("valid face produced zero normal");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	typedef struct {
		logic [15:0] nx, ny, nz;
		logic        flipped, degen;
	} normal_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [383:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [47:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	logic [383:0] face_q[$];
	normal_t      normal_q[$];
	int           errors = 0;
	int           cycles = 0;
	int           sent = 0;
	int           hold_at = 300;
	bit           in_fire = 1'b0;
	bit           filled = 1'b0;

	oriented_face_unit_normal_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #2 clk = ~clk;

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] t;
		res = '0;
		for (int b = 31; b >= 0; b--) begin
			t = res | (64'd1 << b);
			if (t * t <= v)
				res = t;
		end
		return res;
	endfunction

	function automatic normal_t face_normal(input logic [383:0] d);
		logic signed [127:0] w[12];
		logic signed [127:0] e[3], f[3], g[3], n[3], dot;
		logic [127:0]        mag[3];
		logic [63:0]         m[3], r2, r, q;
		logic                neg[3];
		int                  len;
		normal_t             res;
		logic [15:0]         o[3];
		for (int k = 0; k < 12; k++)
			w[k] = $signed(d[32*k +: 32]);
		for (int k = 0; k < 3; k++) begin
			e[k] = w[3+k] - w[k];
			f[k] = w[6+k] - w[k];
			g[k] = w[9+k] - w[k];
		end
		n[0] = e[1] * f[2] - e[2] * f[1];
		n[1] = e[2] * f[0] - e[0] * f[2];
		n[2] = e[0] * f[1] - e[1] * f[0];
		dot = n[0] * g[0] + n[1] * g[1] + n[2] * g[2];
		res.flipped = dot < 0;
		len = 0;
		for (int k = 0; k < 3; k++) begin
			mag[k] = n[k] < 0 ? -n[k] : n[k];
			neg[k] = (n[k] < 0) ^ res.flipped;
			for (int b = 0; b < 128; b++)
				if (mag[k][b] && b + 1 > len)
					len = b + 1;
		end
		res.degen = len == 0;
		res.nx = '0; res.ny = '0; res.nz = '0;
		if (len == 0)
			return res;
		r2 = '0;
		for (int k = 0; k < 3; k++) begin
			m[k] = len > ofun_pkg::TopW ? 64'(mag[k] >> (len - ofun_pkg::TopW))
				: 64'(mag[k] << (ofun_pkg::TopW - len));
			r2 += m[k] * m[k];
		end
		r = root64(r2);
		for (int k = 0; k < 3; k++) begin
			q = ((m[k] << ofun_pkg::NORMAL_FRAC_BITS_DEF) + (r >> 1)) / r;
			if (q > (64'd1 << ofun_pkg::NORMAL_FRAC_BITS_DEF))
				q = 64'd1 << ofun_pkg::NORMAL_FRAC_BITS_DEF;
			if (neg[k]) begin
				if (q > 64'd32768)
					q = 64'd32768;
				o[k] = 16'(-q);
			end else begin
				if (q > 64'd32767)
					q = 64'd32767;
				o[k] = q[15:0];
			end
		end
		res.nx = o[0]; res.ny = o[1]; res.nz = o[2];
		return res;
	endfunction

	function automatic logic [383:0] pack_face(input logic [31:0] c[12]);
		logic [383:0] d;
		for (int k = 0; k < 12; k++)
			d[32*k +: 32] = c[k];
		return d;
	endfunction

	function automatic void add_face(input logic [383:0] d);
		face_q.insert(face_q.size(), d);
	endfunction

	function automatic logic [31:0] jitter();
		return $unsigned($signed($urandom) >>> $urandom_range(4, 31));
	endfunction

	function automatic logic [383:0] random_face();
		logic [31:0] c[12];
		logic [31:0] base;
		int          mode;
		mode = $urandom_range(0, 9);
		for (int k = 0; k < 12; k++)
			c[k] = $urandom;
		if (mode >= 3) begin
			for (int k = 0; k < 3; k++) begin
				base = $unsigned($signed($urandom) >>> 2);
				c[k] = base;
				c[3+k] = base + jitter();
				c[6+k] = base + jitter();
				c[9+k] = base + jitter();
			end
		end
		if (mode == 7)
			for (int k = 0; k < 3; k++)
				c[6+k] = c[k] + (c[3+k] - c[k]) * $urandom_range(0, 3);
		if (mode == 8)
			for (int k = 0; k < 3; k++)
				c[9+k] = $urandom_range(0, 1) ? c[k] : c[6+k];
		if (mode == 9)
			for (int k = 0; k < 3; k++)
				c[3+k] = c[k];
		return pack_face(c);
	endfunction

	// directed faces, then random
	initial begin
		logic [31:0] c[12];
		logic [31:0] mx, mn;
		mx = 32'h7fffffff;
		mn = 32'h80000000;
		add_face('0);
		add_face({12{32'hffffffff}});
		c = '{0, 0, 0, 32'h100000, 0, 0, 0, 32'h100000, 0, 0, 0, 32'h100000};
		add_face(pack_face(c));
		c[11] = -32'sd1048576;
		add_face(pack_face(c));
		c[11] = 0;
		add_face(pack_face(c));
		c = '{mn, mn, mn, mx, mn, mn, mn, mx, mn, mx, mx, mx};
		add_face(pack_face(c));
		c = '{mx, mx, mx, mn, mx, mx, mx, mn, mx, mn, mn, mn};
		add_face(pack_face(c));
		c = '{mn, mx, mn, mx, mn, mx, mn, mx, mx, 0, 0, 0};
		add_face(pack_face(c));
		c = '{0, 0, 0, 1, 0, 0, 0, 1, 0, mn, mn, mn};
		add_face(pack_face(c));
		c = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 5, 0, 0};
		add_face(pack_face(c));
		c = '{0, 0, 0, mx, 0, 0, 0, 1, 0, 0, 0, 1};
		add_face(pack_face(c));
		c = '{0, 0, 0, 1, 2, 0, 2, 1, 0, 0, 0, mn};
		add_face(pack_face(c));
		c = '{0, 0, 0, 3, 0, 0, 0, 3, 0, 0, 0, 0};
		add_face(pack_face(c));
		c = '{mx, 0, 0, mn, 0, 0, 0, mx, mn, mx, mx, mx};
		add_face(pack_face(c));
		c = '{1, 1, 0, 2, 3, 0, 4, 1, 7, mn, mx, 0};
		add_face(pack_face(c));
		for (int i = 0; i < 1090; i++)
			add_face(random_face());
		filled = 1'b1;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (face_q.size() == 0 && !s_axis_tvalid && normal_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && normal_q.size() == 0)
			$display("oriented_face_unit_normal_top verification clean");
		else
			$display("oriented_face_unit_normal_top verification failed");
		$finish;
	end

	// face driver
	always @(negedge clk) begin
		bit calm, hold;
		calm = sent >= 500 && sent < 750;
		if (arst_n) begin
			if (s_axis_tvalid && in_fire)
				sent = sent + 1;
			hold = sent == hold_at && normal_q.size() != 0;
			if (!s_axis_tvalid || in_fire) begin
				if (face_q.size() != 0 && !hold && (calm || $urandom_range(0, 99) >= 34)) begin
					s_axis_tdata <= face_q.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= calm || $urandom_range(0, 99) >= 34;
		end
	end

	// monitor and scoreboard
	always @(posedge clk) begin
		normal_t want;
		in_fire = s_axis_tvalid && s_axis_tready;
		cycles = cycles + 1;
		if (cycles > 200000) begin
			$display("oriented_face_unit_normal_top verification failed");
			$finish;
		end else begin
			if (arst_n && in_fire)
				normal_q.insert(normal_q.size(), face_normal(s_axis_tdata));
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (normal_q.size() == 0) begin
					errors++;
					$display("%0t unexpected beat: expected none, actual %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
				end else begin
					want = normal_q.pop_front();
					if (m_axis_tdata !== {want.nz, want.ny, want.nx} ||
						m_axis_tuser !== {want.degen, want.flipped}) begin
						errors++;
						$display("%0t mismatch: expected z/y/x %h flip %b degen %b, actual %h/%b",
							$time, {want.nz, want.ny, want.nx}, want.flipped, want.degen,
							m_axis_tdata, m_axis_tuser);
					end
				end
			end
		end
	end

endmodule
